FILE: hdl/satp_pkg.sv
// ----------------------------------------------------------------------------
// satp_pkg
// Shared widths, constants and types of the scope averager.
// ----------------------------------------------------------------------------
package satp_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int SPP_W           = 11;
    localparam int ROW_W           = 16;
    localparam int HEIGHT_W        = 12;
    localparam int MV_W            = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MAX_AVERAGE_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SPP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd4;

    localparam logic [SPP_W-1:0]    RST_SPP    = 11'd64;
    localparam logic [ROW_W-1:0]    RST_OFFSET = 16'd0;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd320;
    localparam logic [MV_W-1:0]     RST_LEVEL  = 12'd1650;

    localparam int QUEUE_DEPTH = 2;

    // quotient of a point average always fits the sample width
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // avg / 20 as (avg * 3277) >> 16, exact for avg below 4096
    localparam int RECIP20    = 3277;
    localparam int RECIP20_SH = 16;
    localparam int D20_FULL_W = 24;
    localparam int D20_W      = 8;

    // avg * 82 / 100: estimate with (p * 5242) >> 19, then one correction
    localparam int MV_SCALE    = 82;
    localparam int MV_DIV      = 100;
    localparam int PROD_W      = 19;
    localparam int RECIP100    = 5242;
    localparam int RECIP100_SH = 19;
    localparam int EST_FULL_W  = 32;

    typedef struct packed {
        logic [ROW_W-1:0]    offset;
        logic [HEIGHT_W-1:0] height;
        logic [MV_W-1:0]     level;
        logic                enable;
    } t_back_cfg;

    typedef struct packed {
        logic [MV_W-1:0]  peak;
        logic             crossing;
        logic [MV_W-1:0]  mv;
        logic [ROW_W-1:0] row;
    } t_point_out;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SCALE,
        BK_EST,
        BK_FIX,
        BK_OUT
    } t_back_state;

endpackage

FILE: hdl/scope_average_trigger_peak_core.sv
// ----------------------------------------------------------------------------
// scope_average_trigger_peak_core
// Decimating scope averager with row mapping, millivolt scale, edge flag, peak.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries 12-bit ADC samples, one per cycle at full rate. Every N
//   samples (samples_per_point) form one point, sent on m_axis with display
//   row, millivolts and peak millivolts in tdata and the rising-crossing flag
//   in tuser.
//   Samples that do not close a point are always taken. A closing sample is
//   taken while the two-entry point queue has room.
//   After its closing sample, a point passes a queue pop, 12 divider steps
//   (one quotient bit per cycle, restoring division), 3 scaling stages and
//   an output load when the output is free. The back end takes its next
//   point only after the last one is loaded into the output register.
//   When m_axis stalls, the result waits in the output register, the back
//   end holds its next point, and the queue fills; samples keep flowing until
//   a closing sample finds the queue full.
//   Reset clears the accumulator, the queue, the peak, the previous point and
//   sets the registers to their defaults. Write registers only while idle.
// ----------------------------------------------------------------------------
module scope_average_trigger_peak_core
    import satp_pkg::*;
#(
    parameter int MAX_AVERAGE = MAX_AVERAGE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [11:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // [15:0] display_row, [27:16] millivolts,
                                                 // [39:28] peak_millivolts
    output logic                  m_axis_tuser,  // [0] crossing
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_AVERAGE + 1);
    localparam int SW = CW + SAMPLE_W;

    logic [SPP_W-1:0]    r_cfg_spp;
    logic [ROW_W-1:0]    r_cfg_offset;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic [MV_W-1:0]     r_cfg_level;
    logic                r_cfg_enable;

    logic          q_full;
    logic          push;
    logic [SW-1:0] push_sum;
    logic [CW-1:0] push_count;
    logic          pop;
    logic          q_valid;
    logic [SW+CW-1:0] q_data;
    t_back_cfg     back_cfg;
    t_point_out    point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_spp    <= RST_SPP;
            r_cfg_offset <= RST_OFFSET;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_level  <= RST_LEVEL;
            r_cfg_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPP:    r_cfg_spp    <= i_cfg_data[SPP_W-1:0];
                CFG_OFFSET: r_cfg_offset <= i_cfg_data[ROW_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_LEVEL:  r_cfg_level  <= i_cfg_data[MV_W-1:0];
                CFG_ENABLE: r_cfg_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.offset = r_cfg_offset;
    assign back_cfg.height = r_cfg_height;
    assign back_cfg.level  = r_cfg_level;
    assign back_cfg.enable = r_cfg_enable;

    satp_front #(
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_spp        (r_cfg_spp),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_sum   (push_sum),
        .o_push_count (push_count)
    );

    satp_queue #(
        .W (SW + CW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_sum, push_count}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    satp_back #(
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (back_cfg),
        .i_q_valid (q_valid),
        .i_sum     (q_data[SW+CW-1:CW]),
        .i_count   (q_data[CW-1:0]),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_point   (point)
    );

    assign m_axis_tdata = {point.peak, point.mv, point.row};
    assign m_axis_tuser = point.crossing;

endmodule

FILE: hdl/satp_front.sv
// ----------------------------------------------------------------------------
// satp_front
// Sample accumulator: sums samples and hands each finished point to the queue.
// ----------------------------------------------------------------------------
module satp_front
    import satp_pkg::*;
#(
    parameter int MAX_AVERAGE = MAX_AVERAGE_DEF,
    localparam int CW = $clog2(MAX_AVERAGE + 1),
    localparam int SW = CW + SAMPLE_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SPP_W-1:0]    i_spp,
    input  logic                i_q_full,
    output logic                o_push,
    output logic [SW-1:0]       o_push_sum,
    output logic [CW-1:0]       o_push_count
);

    localparam int EW = (CW > SPP_W) ? CW : SPP_W;

    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_count;
    logic [EW-1:0] spp_ext;
    logic [EW-1:0] eff_wide;
    logic [CW-1:0] eff;
    logic [CW-1:0] count_inc;
    logic [SW-1:0] sum_inc;
    logic          point_done;
    logic          accept;

    always_comb begin
        spp_ext = EW'(i_spp);
        if (spp_ext == '0) begin
            eff_wide = EW'(1);
        end else if (spp_ext > EW'(MAX_AVERAGE)) begin
            eff_wide = EW'(MAX_AVERAGE);
        end else begin
            eff_wide = spp_ext;
        end
        eff        = CW'(eff_wide);
        count_inc  = r_count + CW'(1);
        sum_inc    = r_sum + SW'(i_sample);
        point_done = (count_inc >= eff);
    end

    assign o_ready      = !i_q_full || !point_done;
    assign accept       = i_valid && o_ready;
    assign o_push       = accept && point_done;
    assign o_push_sum   = sum_inc;
    assign o_push_count = count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (point_done) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_inc;
                r_count <= count_inc;
            end
        end
    end

endmodule

FILE: hdl/satp_queue.sv
// ----------------------------------------------------------------------------
// satp_queue
// Short register queue of finished point sums between front and back.
// ----------------------------------------------------------------------------
module satp_queue
    import satp_pkg::*;
#(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;

    assign o_full  = (r_fill == FW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("pop from empty queue");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH)) else $error("queue fill out of range");
`endif

endmodule

FILE: hdl/satp_back.sv
// ----------------------------------------------------------------------------
// satp_back
// Point processor: divides sum by count, scales, flags crossings, holds peak.
// ----------------------------------------------------------------------------
module satp_back
    import satp_pkg::*;
#(
    parameter int MAX_AVERAGE = MAX_AVERAGE_DEF,
    localparam int CW = $clog2(MAX_AVERAGE + 1),
    localparam int SW = CW + SAMPLE_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_back_cfg     i_cfg,
    input  logic          i_q_valid,
    input  logic [SW-1:0] i_sum,
    input  logic [CW-1:0] i_count,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_point_out    o_point
);

    t_back_state r_state;
    t_back_state n_state;

    logic [CW-1:0]       r_rem;
    logic [CW-1:0]       r_div;
    logic [SAMPLE_W-1:0] r_dvd_lo;
    logic [SAMPLE_W-1:0] r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [PROD_W-1:0]   r_prod;
    logic [D20_W-1:0]    r_d20;
    logic [MV_W-1:0]     r_qe;
    logic [MV_W-1:0]     r_mv;
    logic [MV_W-1:0]     r_peak;
    logic [MV_W-1:0]     r_prev_mv;
    logic                r_prev_valid;
    logic                r_out_valid;
    t_point_out          r_out;

    logic [CW:0]           trial;
    logic [CW:0]           diff;
    logic                  ge;
    logic [CW-1:0]         rem_next;
    logic [D20_FULL_W-1:0] d20_full;
    logic [EST_FULL_W-1:0] est_full;
    logic [PROD_W-1:0]     back_full;
    logic [PROD_W-1:0]     rem100;
    logic [ROW_W-1:0]      row;
    logic                  crossing;
    logic [MV_W-1:0]       peak_next;
    logic                  load_out;
    logic                  last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_out  = 1'b0;
        last_step = (r_step == STEP_W'(DIV_STEPS - 1));
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_step) begin
                    n_state = BK_SCALE;
                end
            end
            BK_SCALE: n_state = BK_EST;
            BK_EST:   n_state = BK_FIX;
            BK_FIX:   n_state = BK_OUT;
            BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        trial     = {r_rem, r_dvd_lo[SAMPLE_W-1]};
        diff      = trial - {1'b0, r_div};
        ge        = (trial >= {1'b0, r_div});
        rem_next  = ge ? CW'(diff) : CW'(trial);
        d20_full  = D20_FULL_W'(r_quo) * D20_FULL_W'(RECIP20);
        est_full  = EST_FULL_W'(r_prod) * EST_FULL_W'(RECIP100);
        back_full = PROD_W'(r_qe) * PROD_W'(MV_DIV);
        rem100    = r_prod - back_full;
        row       = ROW_W'(i_cfg.height) - i_cfg.offset - ROW_W'(r_d20);
        crossing  = i_cfg.enable && r_prev_valid && (r_prev_mv < i_cfg.level)
                    && (r_mv >= i_cfg.level);
        peak_next = (r_mv > r_peak) ? r_mv : r_peak;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_rem    <= i_sum[SW-1:SAMPLE_W];
                r_dvd_lo <= i_sum[SAMPLE_W-1:0];
                r_div    <= i_count;
                r_step   <= '0;
            end
            BK_DIV: begin
                r_rem    <= rem_next;
                r_dvd_lo <= {r_dvd_lo[SAMPLE_W-2:0], 1'b0};
                r_quo    <= {r_quo[SAMPLE_W-2:0], ge};
                r_step   <= r_step + STEP_W'(1);
            end
            BK_SCALE: begin
                r_prod <= PROD_W'(r_quo) * PROD_W'(MV_SCALE);
                r_d20  <= D20_W'(d20_full >> RECIP20_SH);
            end
            BK_EST: begin
                r_qe <= MV_W'(est_full >> RECIP100_SH);
            end
            BK_FIX: begin
                r_mv <= (rem100 >= PROD_W'(MV_DIV)) ? r_qe + MV_W'(1) : r_qe;
            end
            BK_OUT: begin
                if (load_out) begin
                    r_out.row      <= row;
                    r_out.mv       <= r_mv;
                    r_out.crossing <= crossing;
                    r_out.peak     <= peak_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_prev_mv    <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_peak       <= peak_next;
                r_prev_mv    <= r_mv;
                r_prev_valid <= 1'b1;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_out;

`ifndef SYNTHESIS
    a_peak_covers_mv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point.peak >= o_point.mv)) else $error("peak below point");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_rem < r_div)) else $error("divider remainder overflow");
`endif

endmodule
